@@ design/blc_pkg.sv @@
// Package: constants, types and the Horner product for the logistic closure unit.
package blc_pkg;
  localparam int unsigned FracBitsDefault = 24;
  localparam logic [31:0] LowerReset = 32'd16775539;
  localparam logic [31:0] UpperReset = 32'd201328230;
  localparam logic [31:0] Ln2Q30 = 32'd744261118;
  localparam logic [30:0] Q30One = 31'h4000_0000;
  localparam int unsigned ExpTerms = 12;
  localparam int unsigned DivStages = 30;

  typedef enum logic [0:0] {
    REG_LOWER = 1'b0,
    REG_UPPER = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic        vld;
    logic        last;
    logic        pos;
    logic        sat;
    logic        neg;
  } ctl_t;

  // floor(r*acc/2^30); r < ln2 in Q30 and acc <= 2^30, so the result fits 30 bits
  function automatic logic [29:0] horner_mul(input logic [29:0] r, input logic [30:0] acc);
    logic [60:0] prod;
    begin
      prod = {31'd0, r} * {30'd0, acc};
      horner_mul = prod[59:30];
    end
  endfunction
endpackage

@@ design/bounded_logistic_closure_unit.sv @@
// Top level: pipelined bounded logistic closure value and slope.
//  channel | ports                                   | handshake
//  cmd     | start_i, dual_value_i, last_element_i   | start_i & !busy_o
//  result  | done_o, state_value_o, state_slope_o, last_out_o | done_o, one cycle
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata  | APB, pready high
// One item per cycle; done_o follows the accepting edge through
// 2 range reduction stages, 24 Horner stages (two per term), 30 divider
// stages and 4 product and output stages.
// busy_o is always low; reset clears the control line and loads the bound registers. No stall exists.
module bounded_logistic_closure_unit
  import blc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] dual_value_i,
  input  logic        last_element_i,
  output logic        done_o,
  output logic [31:0] state_value_o,
  output logic [31:0] state_slope_o,
  output logic        last_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned HLat = 2 * ExpTerms;
  localparam int unsigned DivLat = DivStages;
  localparam int unsigned Lat = 2 + HLat + DivLat + 4;
  // floor(2^40 / ln2_q30); always at or just below the true reciprocal
  localparam logic [10:0] Ln2Recip = 11'd1477;

  logic [31:0] lower_q, upper_q;
  logic        wr;
  reg_idx_e    widx;
  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign widx = reg_idx_e'(paddr[2]);
  assign wr = psel & penable & pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LowerReset;
      upper_q <= UpperReset;
    end else if (wr && paddr[1:0] == 2'd0) begin
      case (widx)
        REG_LOWER: lower_q <= pwdata;
        REG_UPPER: upper_q <= pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    case (widx)
      REG_LOWER: prdata = lower_q;
      REG_UPPER: prdata = upper_q;
      default:   prdata = 32'd0;
    endcase
  end

  // control shift line
  ctl_t ctl_q [Lat+1];
  ctl_t ctl_in;
  logic [31:0] x_mag;
  assign x_mag = dual_value_i[31] ? 32'(-dual_value_i) : dual_value_i;
  always_comb begin
    ctl_in.vld  = start_i;
    ctl_in.last = last_element_i;
    ctl_in.pos  = !dual_value_i[31] && dual_value_i != 32'd0;
    ctl_in.neg  = dual_value_i[31];
    ctl_in.sat  = {32'd0, x_mag} >= (64'd32 << FRAC_BITS);
  end
  assign ctl_q[0] = ctl_in;
  for (genvar i = 0; i < Lat; i++) begin : g_ctl
    ctl_t c_r;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) c_r <= '0;
      else         c_r <= ctl_q[i];
    end
    assign ctl_q[i+1] = c_r;
  end

  // stage 1: t in Q30 and a reciprocal estimate of n = t / ln2
  logic [35:0] t_q;
  logic [6:0]  ne_q;
  logic [35:0] t_in;
  logic [46:0] ne_prod;
  assign t_in = 36'({4'd0, x_mag[31:0]} << (30 - FRAC_BITS));
  assign ne_prod = {11'd0, t_in} * 47'(Ln2Recip);
  always_ff @(posedge clk_i) begin
    t_q  <= t_in;
    ne_q <= 7'(ne_prod >> 40);
  end
  // stage 2: estimate is at most one low, one correction step
  logic [29:0] r_q;
  logic [5:0]  n_q;
  logic [6:0]  n_c;
  logic [35:0] r_c;
  always_comb begin
    n_c = ne_q;
    r_c = t_q - 36'(ne_q) * 36'(Ln2Q30);
    if (r_c >= 36'(Ln2Q30)) begin
      n_c = ne_q + 7'd1;
      r_c = r_c - 36'(Ln2Q30);
    end
  end
  always_ff @(posedge clk_i) begin
    r_q <= r_c[29:0];
    n_q <= n_c[5:0];
  end

  // Horner stages: product, then divide by the term index via reciprocal
  logic [30:0] acc_q [ExpTerms+1];
  logic [29:0] rr_q  [ExpTerms+1];
  logic [5:0]  nn_q  [ExpTerms+1];
  assign acc_q[0] = Q30One;
  assign rr_q[0]  = r_q;
  assign nn_q[0]  = n_q;
  for (genvar k = 0; k < ExpTerms; k++) begin : g_h
    localparam int unsigned Div = ExpTerms - k;
    localparam int unsigned DivLog = $clog2(Div);
    localparam logic [31:0] DivRecip =
      32'(((64'd1 << (30 + DivLog)) + 64'(Div) - 64'd1) / 64'(Div));
    logic [29:0] v_r, r_a, r_r;
    logic [5:0]  n_a, n_r;
    logic [30:0] a_r;
    logic [61:0] tprod;
    logic [30:0] term;
    always_ff @(posedge clk_i) begin
      v_r <= horner_mul(rr_q[k], acc_q[k]);
      r_a <= rr_q[k];
      n_a <= nn_q[k];
    end
    assign tprod = {32'd0, v_r} * {30'd0, DivRecip};
    assign term = 31'(tprod >> (30 + DivLog));
    always_ff @(posedge clk_i) begin
      a_r <= (term >= Q30One) ? 31'd0 : Q30One - term;
      r_r <= r_a;
      n_r <= n_a;
    end
    assign acc_q[k+1] = a_r;
    assign rr_q[k+1]  = r_r;
    assign nn_q[k+1]  = n_r;
  end
  logic [30:0] e_w;
  assign e_w = acc_q[ExpTerms] >> nn_q[ExpTerms];

  logic [30:0] q_w;
  blc_div u_div (.clk_i(clk_i), .e_i(e_w), .en_i(1'b1), .q_o(q_w));

  ctl_t cd;
  assign cd = ctl_q[2 + HLat + DivLat];
  logic [30:0] s_q, sc_q;
  logic [32:0] d_q;
  always_ff @(posedge clk_i) begin
    s_q  <= cd.pos ? Q30One - q_w : q_w;
    sc_q <= cd.pos ? q_w : Q30One - q_w;
    d_q  <= 33'($signed(upper_q)) - 33'($signed(lower_q));
  end
  logic [61:0] ssc;
  logic [30:0] w_q, s2_q;
  logic [32:0] d2_q;
  assign ssc = {31'd0, s_q} * {31'd0, sc_q};
  always_ff @(posedge clk_i) begin
    w_q  <= 31'((ssc + 62'(Q30One >> 1)) >> 30);
    s2_q <= s_q;
    d2_q <= d_q;
  end
  logic [32:0] dmag;
  logic [32:0] pv_q, pw_q;
  logic        dneg_q;
  assign dmag = d2_q[32] ? 33'(-d2_q) : d2_q;
  always_ff @(posedge clk_i) begin
    pv_q   <= 33'(({31'd0, dmag} * {33'd0, s2_q} + 64'(Q30One >> 1)) >> 30);
    pw_q   <= 33'(({31'd0, dmag} * {33'd0, w_q} + 64'(Q30One >> 1)) >> 30);
    dneg_q <= d2_q[32];
  end

  function automatic logic [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647)       sat32 = 32'h7fff_ffff;
    else if (v < -65'sd2147483648) sat32 = 32'h8000_0000;
    else                           sat32 = v[31:0];
  endfunction

  ctl_t co;
  assign co = ctl_q[Lat-1];
  logic signed [64:0] pvs, pws, lows, vv, ww;
  assign pvs  = $signed({32'd0, pv_q});
  assign pws  = $signed({32'd0, pw_q});
  assign lows = 65'($signed(lower_q));
  assign vv = lows + (dneg_q ? -pvs : pvs);
  assign ww = dneg_q ? -pws : pws;
  always_ff @(posedge clk_i) begin
    if (co.sat) begin
      state_value_o <= co.pos ? upper_q : lower_q;
      state_slope_o <= 32'd0;
    end else begin
      state_value_o <= sat32(vv);
      state_slope_o <= sat32(ww);
    end
    last_out_o <= co.last;
  end
  assign done_o = ctl_q[Lat].vld;

  a_busy: assert property (@(posedge clk_i) !busy_o) else $error("busy");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(Lat) done_o) else $error("latency");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ctl_q[Lat].sat |-> state_slope_o == 32'd0) else $error("sat slope");
endmodule

@@ design/blc_div.sv @@
// Restoring divider stage chain: q = floor(e*2^30/(2^30+e)), one quotient bit per stage.
module blc_div
  import blc_pkg::*;
(
  input  logic        clk_i,
  input  logic [30:0] e_i,
  input  logic        en_i,
  output logic [30:0] q_o
);
  // e < 2^30 + e, so the upper half of the numerator gives no quotient bits;
  // the remainder starts at e and the low 30 numerator bits are zero
  logic [31:0] den_q  [DivStages+1];
  logic [31:0] rem_q  [DivStages+1];
  logic [29:0] quo_q  [DivStages+1];

  assign den_q[0] = {1'b0, Q30One} + {1'b0, e_i};
  assign rem_q[0] = {1'b0, e_i};
  assign quo_q[0] = 30'd0;

  for (genvar i = 0; i < DivStages; i++) begin : g_st
    logic [32:0] trial;
    logic [31:0] den_r, rem_r;
    logic [29:0] quo_r;
    assign trial = {rem_q[i], 1'b0};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_r <= den_q[i];
        if (trial >= {1'b0, den_q[i]}) begin
          rem_r <= 32'(trial - {1'b0, den_q[i]});
          quo_r <= {quo_q[i][28:0], 1'b1};
        end else begin
          rem_r <= trial[31:0];
          quo_r <= {quo_q[i][28:0], 1'b0};
        end
      end
    end
    assign den_q[i+1] = den_r;
    assign rem_q[i+1] = rem_r;
    assign quo_q[i+1] = quo_r;
  end

  assign q_o = {1'b0, quo_q[DivStages]};
endmodule

@@ tb/sv/bounded_logistic_closure_unit_tb.sv @@
// Testbench for the bounded logistic closure unit: predicted value/slope/last checked per item.
`timescale 1ns / 100ps

module bounded_logistic_closure_unit_tb
  import blc_pkg::*;
();

  typedef struct {
    logic [31:0] dual;
    logic        last;
  } dual_item_t;

  typedef struct {
    logic [31:0] value;
    logic [31:0] slope;
    logic        last;
  } closure_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] dual_value_i = '0;
  logic        last_element_i = 1'b0;
  logic        done_o;
  logic [31:0] state_value_o;
  logic [31:0] state_slope_o;
  logic        last_out_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bounded_logistic_closure_unit i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  dual_item_t   pending_items[$];
  closure_res_t expected_res[$];
  longint       lower_model = longint'(signed'(LowerReset));
  longint       upper_model = longint'(signed'(UpperReset));
  bit           feed_en = 1'b0;
  bit           no_idle = 1'b0;
  int           gap_cnt = 0;
  int           mismatches = 0;
  int           n_checked = 0;
  int           n_sat = 0;
  longint       cycles = 0;

  function automatic longint round_q30(longint a, longint unsigned m);
    longint unsigned mag;
    longint unsigned prod;
    begin
      mag = (a < 0) ? longint'(-a) : longint'(a);
      prod = (mag * m + 64'd536870912) >> 30;
      round_q30 = (a < 0) ? -longint'(prod) : longint'(prod);
    end
  endfunction

  function automatic longint clamp32(longint v);
    begin
      if (v > 64'sd2147483647) clamp32 = 64'sd2147483647;
      else if (v < -64'sd2147483648) clamp32 = -64'sd2147483648;
      else clamp32 = v;
    end
  endfunction

  function automatic closure_res_t predict_closure(dual_item_t it);
    closure_res_t res;
    longint x, d, value, slope;
    longint unsigned mag, t, n, r, acc, term, e, q, p, s, sc, w;
    begin
      x = longint'(signed'(it.dual));
      mag = (x < 0) ? longint'(-x) : longint'(x);
      d = upper_model - lower_model;
      if (mag >= (64'd32 << 24)) begin
        value = (x > 0) ? upper_model : lower_model;
        slope = 0;
      end else begin
        t = mag << 6;
        n = t / 64'd744261118;
        r = t - n * 64'd744261118;
        acc = 64'd1 << 30;
        for (int k = ExpTerms; k >= 1; k--) begin
          term = ((r * acc) >> 30) / longint'(k);
          acc = (term >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - term;
        end
        e = (n >= 63) ? 64'd0 : (acc >> n);
        q = (e << 30) / ((64'd1 << 30) + e);
        p = (64'd1 << 30) - q;
        s = (x > 0) ? p : q;
        sc = (x > 0) ? q : p;
        w = (s * sc + 64'd536870912) >> 30;
        value = clamp32(lower_model + round_q30(d, s));
        slope = clamp32(round_q30(d, w));
      end
      res.value = value[31:0];
      res.slope = slope[31:0];
      res.last = it.last;
      predict_closure = res;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    dual_item_t it;
    if (start_i && !busy_o) begin
      it.dual = dual_value_i;
      it.last = last_element_i;
      expected_res.push_back(predict_closure(it));
    end
    if (gap_cnt > 0) begin
      gap_cnt <= gap_cnt - 1;
      start_i <= 1'b0;
    end else if (feed_en && pending_items.size() > 0) begin
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        gap_cnt <= $urandom_range(0, 8);
        start_i <= 1'b0;
      end else begin
        it = pending_items.pop_front();
        start_i <= 1'b1;
        dual_value_i <= it.dual;
        last_element_i <= it.last;
      end
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    closure_res_t ex;
    cycles <= cycles + 1;
    if (rst_ni && done_o) begin
      if (expected_res.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result: value %h slope %h", state_value_o,
                                      state_slope_o);
      end else begin
        ex = expected_res.pop_front();
        n_checked <= n_checked + 1;
        if (ex.value !== state_value_o || ex.slope !== state_slope_o ||
            ex.last !== last_out_o) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp value %h slope %h last %b, got %h %h %b",
                     ex.value, ex.slope, ex.last, state_value_o, state_slope_o, last_out_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("timeout");
      $display("bounded_logistic_closure_unit_tb failed");
      $finish;
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LOWER) lower_model = longint'(signed'(data));
    else upper_model = longint'(signed'(data));
  endtask

  task automatic add_item(logic [31:0] v, logic l);
    dual_item_t it;
    logic [31:0] mag;
    it.dual = v;
    it.last = l;
    pending_items.push_back(it);
    mag = v[31] ? 32'(-v) : v;
    if (mag >= 32'h2000_0000) n_sat++;
  endtask

  task automatic run_phase(int n_rand);
    logic [31:0] v;
    add_item(32'h0000_0000, 1'b0);
    add_item(32'h0000_0001, 1'b1);
    add_item(32'hFFFF_FFFF, 1'b0);
    add_item(32'h0100_0000, 1'b0);
    add_item(32'hFF00_0000, 1'b1);
    add_item(32'h00B1_7218, 1'b0);
    add_item(32'h1FFF_FFFF, 1'b0);
    add_item(32'hE000_0001, 1'b1);
    add_item(32'h2000_0000, 1'b0);
    add_item(32'hE000_0000, 1'b1);
    add_item(32'h7FFF_FFFF, 1'b0);
    add_item(32'h8000_0000, 1'b1);
    add_item(32'h0C00_0000, 1'b0);
    add_item(32'hF400_0000, 1'b0);
    for (int i = 0; i < n_rand; i++) begin
      if ($urandom_range(0, 4) == 0) v = $urandom;
      else begin
        v = $urandom_range(0, 32'h1FFF_FFFF) >> $urandom_range(0, 28);
        if ($urandom_range(0, 1)) v = -v;
      end
      add_item(v, $urandom_range(0, 1));
    end
    feed_en = 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk_i);
    @(posedge clk_i);
    feed_en = 1'b0;
    while (expected_res.size() != 0 || start_i) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    run_phase(200);
    apb_write(REG_LOWER, 32'h0000_0000);
    apb_write(REG_UPPER, 32'h0100_0000);
    run_phase(200);
    apb_write(REG_LOWER, 32'h8000_0000);
    apb_write(REG_UPPER, 32'h7FFF_FFFF);
    run_phase(200);
    apb_write(REG_LOWER, 32'h7FFF_FFFF);
    apb_write(REG_UPPER, 32'h8000_0000);
    run_phase(200);
    apb_write(REG_LOWER, 32'h0500_0000);
    apb_write(REG_UPPER, 32'hFD00_0000);
    run_phase(200);
    apb_write(REG_LOWER, 32'h0300_0000);
    apb_write(REG_UPPER, 32'h0300_0000);
    run_phase(100);
    apb_write(REG_LOWER, $urandom);
    apb_write(REG_UPPER, $urandom);
    run_phase(150);
    no_idle = 1'b1;
    apb_write(REG_LOWER, 32'hF000_0000);
    apb_write(REG_UPPER, 32'h6000_0000);
    run_phase(150);
    $display("checked %0d results over 8 bound settings (extreme, inverted, equal, random)",
             n_checked);
    $display("%0d items hit the saturation range, %0d mismatches", n_sat, mismatches);
    if (mismatches == 0) $display("bounded_logistic_closure_unit_tb passed");
    else $display("bounded_logistic_closure_unit_tb failed");
    $finish;
  end
endmodule
